// ----- hw/rtl/hdec_pkg.sv -----
package hdec_pkg;

	localparam int IDX_W       = 9;
	localparam int SYM_W       = 8;
	localparam int OP_W        = 2;
	localparam int BYTE_BITS   = 8;
	localparam int NODE_COUNT  = 512;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD    = 2'd0,
		OP_DECODE  = 2'd1,
		OP_RESTART = 2'd2
	} op_t;

	// one tree node as kept in the table
	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic             leaf;
		logic [IDX_W-1:0] right;
		logic [IDX_W-1:0] left;
	} node_t;

	// classified word handed from the front to the back
	typedef struct packed {
		op_t                  op;
		logic [IDX_W-1:0]     idx;
		node_t                node;
		logic [BYTE_BITS-1:0] code;
	} cmd_t;

	function automatic logic in_table(input logic [IDX_W-1:0] idx, input int count);
		return int'(idx) < count;
	endfunction

endpackage

// ----- hw/rtl/huffman_tree_walk_decoder.sv -----
// Huffman tree-walk decoder.
// Item channel (item_valid / item_stall) takes one word per handshake: a node load,
// a code byte to decode, or a restart of the walk at root_index. Result channel
// (result_valid / result_stall) gives one decoded symbol per word, with last set on
// the final symbol of a code byte; a byte may give zero to eight symbols.
// root_index is written through cfg_wr_en / cfg_wr_data while the block is quiet;
// the new root takes effect at the next leaf or restart.
// Path: a word passes an input stage and a two-entry queue before the walker.
// Loads and restarts are handled in the walker's idle state. A decode reads the
// current node unless it is already held, then spends the bits in order, with an
// extra look-up on a freshly read node at the start of the byte and after every
// leaf, and closes the byte in a done state; the walker takes no new word until the
// byte is closed, its pace set by the single read port of the node table. Each
// symbol is held until the next one or the end of its byte so last can be marked.
// Reset empties the queue and output, puts the walk and root at node 0; the node
// table holds nothing valid until loaded. A stalled result holds, the walker
// pauses, the queue fills and item_stall rises.
module huffman_tree_walk_decoder #(
	parameter int NODE_COUNT  = hdec_pkg::NODE_COUNT,
	parameter int QUEUE_DEPTH = hdec_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [hdec_pkg::IDX_W-1:0]     cfg_wr_data,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic [hdec_pkg::OP_W-1:0]      op,
	input  logic [hdec_pkg::IDX_W-1:0]     node_index,
	input  logic [hdec_pkg::IDX_W-1:0]     left_child,
	input  logic [hdec_pkg::IDX_W-1:0]     right_child,
	input  logic                           leaf_flag,
	input  logic [hdec_pkg::SYM_W-1:0]     leaf_symbol,
	input  logic [hdec_pkg::BYTE_BITS-1:0] code_byte,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [hdec_pkg::SYM_W-1:0]     symbol,
	output logic                           last
);

	logic [hdec_pkg::IDX_W-1:0] root_q;
	logic                       q_push;
	logic                       q_full;
	logic                       q_pop;
	logic                       q_empty;
	hdec_pkg::cmd_t             q_in;
	hdec_pkg::cmd_t             q_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
		end else if (cfg_wr_en) begin
			root_q <= cfg_wr_data;
		end
	end

	hdec_front #(
		.NODE_COUNT(NODE_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.op         (op),
		.node_index (node_index),
		.left_child (left_child),
		.right_child(right_child),
		.leaf_flag  (leaf_flag),
		.leaf_symbol(leaf_symbol),
		.code_byte  (code_byte),
		.push       (q_push),
		.cmd        (q_in),
		.full       (q_full)
	);

	hdec_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_in),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_out),
		.empty    (q_empty)
	);

	hdec_back #(
		.NODE_COUNT(NODE_COUNT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.root_index  (root_q),
		.q_empty     (q_empty),
		.q_data      (q_out),
		.q_pop       (q_pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.symbol      (symbol),
		.last        (last)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue written while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue read while empty");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> q_full)
		else $error("item channel stalled with room in the queue");

endmodule

// ----- hw/rtl/hdec_front.sv -----
module hdec_front #(
	parameter int NODE_COUNT = hdec_pkg::NODE_COUNT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [hdec_pkg::OP_W-1:0]         op,
	input  logic [hdec_pkg::IDX_W-1:0]        node_index,
	input  logic [hdec_pkg::IDX_W-1:0]        left_child,
	input  logic [hdec_pkg::IDX_W-1:0]        right_child,
	input  logic                              leaf_flag,
	input  logic [hdec_pkg::SYM_W-1:0]        leaf_symbol,
	input  logic [hdec_pkg::BYTE_BITS-1:0]    code_byte,
	output logic                              push,
	output hdec_pkg::cmd_t                    cmd,
	input  logic                              full
);

	logic           vld_s1;
	hdec_pkg::cmd_t cmd_s1;
	logic           accept;
	logic           keep;

	// loads outside the table and unused op codes have no effect, drop them here
	always_comb begin
		case (hdec_pkg::op_t'(op))
			hdec_pkg::OP_LOAD:    keep = hdec_pkg::in_table(node_index, NODE_COUNT);
			hdec_pkg::OP_DECODE:  keep = 1'b1;
			hdec_pkg::OP_RESTART: keep = 1'b1;
			default:              keep = 1'b0;
		endcase
	end

	assign item_stall = vld_s1 && full;
	assign push       = vld_s1 && !full;
	assign accept     = item_valid && !item_stall;
	assign cmd        = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= keep;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.op         <= hdec_pkg::op_t'(op);
			cmd_s1.idx        <= node_index;
			cmd_s1.node.left  <= left_child;
			cmd_s1.node.right <= right_child;
			cmd_s1.node.leaf  <= leaf_flag;
			cmd_s1.node.sym   <= leaf_symbol;
			cmd_s1.code       <= code_byte;
		end
	end

endmodule

// ----- hw/rtl/hdec_fifo.sv -----
module hdec_fifo #(
	parameter int DEPTH = hdec_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hdec_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output hdec_pkg::cmd_t pop_data,
	output logic           empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	hdec_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;

	assign full     = cnt_q == CW'(DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- hw/rtl/hdec_back.sv -----
module hdec_back #(
	parameter int NODE_COUNT = hdec_pkg::NODE_COUNT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [hdec_pkg::IDX_W-1:0] root_index,
	input  logic                       q_empty,
	input  hdec_pkg::cmd_t             q_data,
	output logic                       q_pop,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [hdec_pkg::SYM_W-1:0] symbol,
	output logic                       last
);

	localparam int AW    = $clog2(NODE_COUNT);
	localparam int CNT_W = $clog2(hdec_pkg::BYTE_BITS);
	localparam int IW    = hdec_pkg::IDX_W;
	localparam int SW    = hdec_pkg::SYM_W;
	localparam int BW    = hdec_pkg::BYTE_BITS;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_LOOK  = 5'b00010,
		ST_STEP  = 5'b00100,
		ST_CHILD = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	function automatic logic [AW-1:0] to_addr(input logic [IW-1:0] idx);
		logic [IW+AW-1:0] ext;
		ext = {{AW{1'b0}}, idx};
		return ext[AW-1:0];
	endfunction

	hdec_pkg::node_t mem_q [NODE_COUNT];
	hdec_pkg::node_t rd_data_q;
	logic            rd_zero_q;

	state_t          state_q, state_d;
	logic [IW-1:0]   cur_q, cur_d;
	hdec_pkg::node_t ent_q, ent_d;
	logic            ent_vld_q, ent_vld_d;
	logic [IW-1:0]   nxt_q, nxt_d;
	logic [BW-1:0]   bits_q, bits_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic            pend_vld_q, pend_vld_d;
	logic [SW-1:0]   pend_sym_q, pend_sym_d;
	logic            out_vld_q;
	logic [SW-1:0]   out_sym_q;
	logic            out_last_q;

	hdec_pkg::node_t rd_entry;
	hdec_pkg::node_t e_cur;
	logic            can_emit;
	logic            last_bit;
	logic            rd_en;
	logic [IW-1:0]   rd_idx;
	logic            wr_en;
	logic            emit;
	logic [SW-1:0]   emit_sym;
	logic            to_root;
	logic            consume;
	logic            push_out;
	logic            push_last;
	logic [SW-1:0]   push_sym;

	// entries past the table read as zero
	assign rd_entry = rd_zero_q ? '0 : rd_data_q;
	assign e_cur    = (state_q == ST_STEP) ? ent_q : rd_entry;
	assign can_emit = !out_vld_q || !result_stall;
	assign last_bit = cnt_q == CNT_W'(BW - 1);

	always_comb begin
		state_d    = state_q;
		cur_d      = cur_q;
		ent_d      = ent_q;
		ent_vld_d  = ent_vld_q;
		nxt_d      = nxt_q;
		bits_d     = bits_q;
		cnt_d      = cnt_q;
		pend_vld_d = pend_vld_q;
		pend_sym_d = pend_sym_q;
		rd_en      = 1'b0;
		rd_idx     = cur_q;
		wr_en      = 1'b0;
		q_pop      = 1'b0;
		emit       = 1'b0;
		emit_sym   = e_cur.sym;
		to_root    = 1'b0;
		consume    = 1'b0;
		push_out   = 1'b0;
		push_last  = 1'b0;
		push_sym   = pend_sym_q;

		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					case (q_data.op)
						hdec_pkg::OP_LOAD: begin
							wr_en = 1'b1;
							if (q_data.idx == cur_q) begin
								ent_d     = q_data.node;
								ent_vld_d = 1'b1;
							end
						end
						hdec_pkg::OP_RESTART: begin
							cur_d     = root_index;
							ent_vld_d = 1'b0;
						end
						hdec_pkg::OP_DECODE: begin
							bits_d = q_data.code;
							cnt_d  = '0;
							if (ent_vld_q) begin
								state_d = ST_STEP;
							end else begin
								rd_en   = 1'b1;
								rd_idx  = cur_q;
								state_d = ST_LOOK;
							end
						end
						default: ;
					endcase
				end
			end
			ST_LOOK, ST_STEP: begin
				if (can_emit) begin
					if (e_cur.leaf) begin
						// walk sits on a leaf: the bit is spent on it
						emit     = 1'b1;
						emit_sym = e_cur.sym;
						to_root  = 1'b1;
					end else begin
						rd_en   = 1'b1;
						rd_idx  = bits_q[0] ? e_cur.right : e_cur.left;
						nxt_d   = rd_idx;
						state_d = ST_CHILD;
					end
				end
			end
			ST_CHILD: begin
				if (can_emit) begin
					if (rd_entry.leaf) begin
						emit     = 1'b1;
						emit_sym = rd_entry.sym;
						to_root  = 1'b1;
					end else begin
						cur_d     = nxt_q;
						ent_d     = rd_entry;
						ent_vld_d = 1'b1;
						consume   = 1'b1;
						if (last_bit) begin
							state_d = ST_DONE;
						end else begin
							// child is inner, fetch its child for the next bit
							rd_en  = 1'b1;
							rd_idx = bits_q[1] ? rd_entry.right : rd_entry.left;
							nxt_d  = rd_idx;
						end
					end
				end
			end
			ST_DONE: begin
				if (can_emit) begin
					if (pend_vld_q) begin
						push_out   = 1'b1;
						push_last  = 1'b1;
						pend_vld_d = 1'b0;
					end
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		if (to_root) begin
			consume   = 1'b1;
			cur_d     = root_index;
			ent_vld_d = 1'b0;
			if (last_bit) begin
				state_d = ST_DONE;
			end else begin
				rd_en   = 1'b1;
				rd_idx  = root_index;
				state_d = ST_LOOK;
			end
		end

		if (consume) begin
			bits_d = bits_q >> 1;
			cnt_d  = cnt_q + 1'b1;
		end

		// hold one symbol back so that the final one of a byte can be marked
		if (emit) begin
			if (pend_vld_q) begin
				push_out  = 1'b1;
				push_last = 1'b0;
			end
			pend_vld_d = 1'b1;
			pend_sym_d = emit_sym;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cur_q      <= '0;
			ent_vld_q  <= 1'b0;
			cnt_q      <= '0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			cur_q      <= cur_d;
			ent_vld_q  <= ent_vld_d;
			cnt_q      <= cnt_d;
			pend_vld_q <= pend_vld_d;
			if (push_out) begin
				out_vld_q <= 1'b1;
			end else if (!result_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ent_q      <= ent_d;
		nxt_q      <= nxt_d;
		bits_q     <= bits_d;
		pend_sym_q <= pend_sym_d;
		if (push_out) begin
			out_sym_q  <= push_sym;
			out_last_q <= push_last;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[to_addr(q_data.idx)] <= q_data.node;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[to_addr(rd_idx)];
			rd_zero_q <= !hdec_pkg::in_table(rd_idx, NODE_COUNT);
		end
	end

	assign result_valid = out_vld_q;
	assign symbol       = out_sym_q;
	assign last         = out_last_q;

endmodule
